// ===== rtl/tls_pkg.sv =====
// Shared types and constants for the text line statistics block.
`default_nettype none

package tls_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int OUT_BITS           = 32;
   localparam int OUT_FIELDS         = 12;
   localparam int RSP_BITS           = OUT_BITS * OUT_FIELDS;
   localparam int BYTE_BITS          = 8;

   localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'd10;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_EOF  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [BYTE_BITS-1:0] data_byte;
   } beat_type;

   // first member sits in the top bits, so file_bytes lands in bits 31:0
   typedef struct packed {
      logic [OUT_BITS-1:0] most_file_lines;
      logic [OUT_BITS-1:0] fewest_file_lines;
      logic [OUT_BITS-1:0] largest_file_bytes;
      logic [OUT_BITS-1:0] smallest_file_bytes;
      logic [OUT_BITS-1:0] total_empty_lines;
      logic [OUT_BITS-1:0] total_lines;
      logic [OUT_BITS-1:0] total_bytes;
      logic [OUT_BITS-1:0] line_width_max;
      logic [OUT_BITS-1:0] line_width_min;
      logic [OUT_BITS-1:0] file_empty_lines;
      logic [OUT_BITS-1:0] file_lines;
      logic [OUT_BITS-1:0] file_bytes;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/tls_in_stage.sv =====
// Input register stage holding one accepted beat.
`default_nettype none

module tls_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tls_pkg::beat_type in_beat,
   output logic                   out_valid,
   output tls_pkg::beat_type      out_beat,
   input  wire logic              advance
);
   import tls_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;
   logic     in_fire;

   assign in_ready = !valid_ff || advance;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      if (in_fire) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         beat_ff <= in_beat;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

`default_nettype wire

// ===== rtl/tls_file_stats.sv =====
// Per-file byte, line, empty line and line width counters.
`default_nettype none

module tls_file_stats #(
   parameter int COUNT_BITS = tls_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire tls_pkg::beat_type     beat,
   output logic [COUNT_BITS-1:0]      file_bytes,
   output logic [COUNT_BITS-1:0]      file_lines,
   output logic [COUNT_BITS-1:0]      file_empty,
   output logic [COUNT_BITS-1:0]      width_min,
   output logic [COUNT_BITS-1:0]      width_max
);
   import tls_pkg::*;

   localparam logic [COUNT_BITS-1:0] ALL_ONES = '1;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == ALL_ONES) ? v : v + 1'b1;
   endfunction

   // lines_ff already counts a line that is open (bytes since last newline)
   logic [COUNT_BITS-1:0] bytes_ff, bytes_in;
   logic [COUNT_BITS-1:0] lines_ff, lines_in;
   logic [COUNT_BITS-1:0] empty_ff, empty_in;
   logic [COUNT_BITS-1:0] len_ff, len_in;
   logic [COUNT_BITS-1:0] wmin_ff, wmin_in;
   logic [COUNT_BITS-1:0] wmax_ff, wmax_in;
   logic                  line_fresh;
   logic                  is_newline;

   assign line_fresh = (len_ff == '0);
   assign is_newline = (beat.data_byte == NEWLINE_BYTE);

   always_comb begin
      bytes_in = bytes_ff;
      lines_in = lines_ff;
      empty_in = empty_ff;
      len_in   = len_ff;
      wmin_in  = wmin_ff;
      wmax_in  = wmax_ff;
      if (step) begin
         if (beat.kind == KIND_EOF) begin
            bytes_in = '0;
            lines_in = '0;
            empty_in = '0;
            len_in   = '0;
            wmin_in  = ALL_ONES;
            wmax_in  = '0;
         end else begin
            bytes_in = sat_inc(bytes_ff);
            if (line_fresh) begin
               lines_in = sat_inc(lines_ff);
            end
            if (is_newline) begin
               if (len_ff < wmin_ff) begin
                  wmin_in = len_ff;
               end
               if (len_ff > wmax_ff) begin
                  wmax_in = len_ff;
               end
               if (line_fresh) begin
                  empty_in = sat_inc(empty_ff);
               end
               len_in = '0;
            end else begin
               len_in = sat_inc(len_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
         lines_ff <= '0;
         empty_ff <= '0;
         len_ff   <= '0;
         wmin_ff  <= ALL_ONES;
         wmax_ff  <= '0;
      end else begin
         bytes_ff <= bytes_in;
         lines_ff <= lines_in;
         empty_ff <= empty_in;
         len_ff   <= len_in;
         wmin_ff  <= wmin_in;
         wmax_ff  <= wmax_in;
      end
   end

   assign file_bytes = bytes_ff;
   assign file_lines = lines_ff;
   assign file_empty = empty_ff;
   assign width_min  = wmin_ff;
   assign width_max  = wmax_ff;

endmodule

`default_nettype wire

// ===== rtl/tls_totals.sv =====
// Running totals and per-file extremes over all closed files.
`default_nettype none

module tls_totals #(
   parameter int COUNT_BITS = tls_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  close,
   input  wire logic [COUNT_BITS-1:0] file_bytes,
   input  wire logic [COUNT_BITS-1:0] file_lines,
   input  wire logic [COUNT_BITS-1:0] file_empty,
   output logic [COUNT_BITS-1:0]      next_sum_bytes,
   output logic [COUNT_BITS-1:0]      next_sum_lines,
   output logic [COUNT_BITS-1:0]      next_sum_empty,
   output logic [COUNT_BITS-1:0]      next_size_min,
   output logic [COUNT_BITS-1:0]      next_size_max,
   output logic [COUNT_BITS-1:0]      next_lines_min,
   output logic [COUNT_BITS-1:0]      next_lines_max
);
   import tls_pkg::*;

   localparam logic [COUNT_BITS-1:0] ALL_ONES = '1;

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? ALL_ONES : s[COUNT_BITS-1:0];
   endfunction

   logic [COUNT_BITS-1:0] sum_bytes_ff, sum_bytes_in;
   logic [COUNT_BITS-1:0] sum_lines_ff, sum_lines_in;
   logic [COUNT_BITS-1:0] sum_empty_ff, sum_empty_in;
   logic [COUNT_BITS-1:0] size_min_ff, size_min_in;
   logic [COUNT_BITS-1:0] size_max_ff, size_max_in;
   logic [COUNT_BITS-1:0] lines_min_ff, lines_min_in;
   logic [COUNT_BITS-1:0] lines_max_ff, lines_max_in;

   // values as they stand once the current file is folded in
   assign next_sum_bytes = sat_add(sum_bytes_ff, file_bytes);
   assign next_sum_lines = sat_add(sum_lines_ff, file_lines);
   assign next_sum_empty = sat_add(sum_empty_ff, file_empty);
   assign next_size_min  = (file_bytes < size_min_ff) ? file_bytes : size_min_ff;
   assign next_size_max  = (file_bytes > size_max_ff) ? file_bytes : size_max_ff;
   assign next_lines_min = (file_lines < lines_min_ff) ? file_lines : lines_min_ff;
   assign next_lines_max = (file_lines > lines_max_ff) ? file_lines : lines_max_ff;

   always_comb begin
      sum_bytes_in = sum_bytes_ff;
      sum_lines_in = sum_lines_ff;
      sum_empty_in = sum_empty_ff;
      size_min_in  = size_min_ff;
      size_max_in  = size_max_ff;
      lines_min_in = lines_min_ff;
      lines_max_in = lines_max_ff;
      if (close) begin
         sum_bytes_in = next_sum_bytes;
         sum_lines_in = next_sum_lines;
         sum_empty_in = next_sum_empty;
         size_min_in  = next_size_min;
         size_max_in  = next_size_max;
         lines_min_in = next_lines_min;
         lines_max_in = next_lines_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_bytes_ff <= '0;
         sum_lines_ff <= '0;
         sum_empty_ff <= '0;
         size_min_ff  <= ALL_ONES;
         size_max_ff  <= '0;
         lines_min_ff <= ALL_ONES;
         lines_max_ff <= '0;
      end else begin
         sum_bytes_ff <= sum_bytes_in;
         sum_lines_ff <= sum_lines_in;
         sum_empty_ff <= sum_empty_in;
         size_min_ff  <= size_min_in;
         size_max_ff  <= size_max_in;
         lines_min_ff <= lines_min_in;
         lines_max_ff <= lines_max_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/text_line_statistics_top.sv =====
// Top level of the text line statistics block with the result register.
// Throughput: one beat per cycle, data bytes and end-of-file marks alike, except while an end-of-file mark is stalled.
// An accepted end-of-file beat sits in the input register until the result register is
// free to load; the result register then offers the result beat.
// An end-of-file mark stalls the input only while the result register is full and not drained.
// Reset clears all counts and totals to zero and all minima to all ones.
`default_nettype none

module text_line_statistics_top #(
   parameter int COUNT_BITS = tls_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [tls_pkg::BYTE_BITS-1:0]  req_tdata,  // data_byte
   input  wire logic                           req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // file_bytes, file_lines, file_empty_lines, line_width_min, line_width_max,
   // total_bytes, total_lines, total_empty_lines, smallest_file_bytes,
   // largest_file_bytes, fewest_file_lines, most_file_lines (32 bits each)
   output logic [tls_pkg::RSP_BITS-1:0]        rsp_tdata
);
   import tls_pkg::*;

   beat_type              req_beat;
   beat_type              s1_beat;
   logic                  s1_valid;
   logic                  step;
   logic                  close;
   logic                  rsp_free;

   logic [COUNT_BITS-1:0] file_bytes, file_lines, file_empty, width_min, width_max;
   logic [COUNT_BITS-1:0] sum_bytes, sum_lines, sum_empty;
   logic [COUNT_BITS-1:0] size_min, size_max, lines_min, lines_max;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;

   assign req_beat.kind      = kind_type'(req_tuser);
   assign req_beat.data_byte = req_tdata;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign close    = s1_valid && (s1_beat.kind == KIND_EOF) && rsp_free;
   assign step     = (s1_valid && (s1_beat.kind == KIND_DATA)) || close;

   tls_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_beat   (req_beat),
      .out_valid (s1_valid),
      .out_beat  (s1_beat),
      .advance   (step)
   );

   tls_file_stats #(
      .COUNT_BITS (COUNT_BITS)
   ) u_file_stats (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .beat       (s1_beat),
      .file_bytes (file_bytes),
      .file_lines (file_lines),
      .file_empty (file_empty),
      .width_min  (width_min),
      .width_max  (width_max)
   );

   tls_totals #(
      .COUNT_BITS (COUNT_BITS)
   ) u_totals (
      .clock          (clock),
      .reset          (reset),
      .close          (close),
      .file_bytes     (file_bytes),
      .file_lines     (file_lines),
      .file_empty     (file_empty),
      .next_sum_bytes (sum_bytes),
      .next_sum_lines (sum_lines),
      .next_sum_empty (sum_empty),
      .next_size_min  (size_min),
      .next_size_max  (size_max),
      .next_lines_min (lines_min),
      .next_lines_max (lines_max)
   );

   always_comb begin
      rsp_data_in.file_bytes          = OUT_BITS'(file_bytes);
      rsp_data_in.file_lines          = OUT_BITS'(file_lines);
      rsp_data_in.file_empty_lines    = OUT_BITS'(file_empty);
      rsp_data_in.line_width_min      = OUT_BITS'(width_min);
      rsp_data_in.line_width_max      = OUT_BITS'(width_max);
      rsp_data_in.total_bytes         = OUT_BITS'(sum_bytes);
      rsp_data_in.total_lines         = OUT_BITS'(sum_lines);
      rsp_data_in.total_empty_lines   = OUT_BITS'(sum_empty);
      rsp_data_in.smallest_file_bytes = OUT_BITS'(size_min);
      rsp_data_in.largest_file_bytes  = OUT_BITS'(size_max);
      rsp_data_in.fewest_file_lines   = OUT_BITS'(lines_min);
      rsp_data_in.most_file_lines     = OUT_BITS'(lines_max);
   end

   always_comb begin
      if (close) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (close) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/text_line_statistics_checker.sv =====
// Checker for the text line statistics block: predicts each per-file result and compares it.
module text_line_statistics_checker #(
   parameter int COUNT_BITS = tls_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [tls_pkg::BYTE_BITS-1:0] req_tdata,  // data_byte
   input  wire logic                          req_tuser,  // kind
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [tls_pkg::RSP_BITS-1:0]  rsp_tdata,  // result_type, file_bytes lowest
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 checked_count
);
   import tls_pkg::*;

   typedef logic [COUNT_BITS-1:0] count_t;
   localparam count_t COUNT_MAX = '1;

   count_t file_bytes, file_lines, file_empty, line_len, width_min, width_max;
   count_t run_bytes, run_lines, run_empty, size_lo, size_hi, lines_lo, lines_hi;
   result_type file_stats_q[$];
   result_type got, want;

   function automatic count_t bump(count_t v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic count_t add_sat(count_t a, count_t b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [OUT_BITS-1:0] low_bits(count_t v);
      return OUT_BITS'(v);
   endfunction

   task automatic clear_file();
      file_bytes = '0;
      file_lines = '0;
      file_empty = '0;
      line_len   = '0;
      width_min  = COUNT_MAX;
      width_max  = '0;
   endtask

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= 30) $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [OUT_BITS-1:0] g,
                              input logic [OUT_BITS-1:0] w);
      if (g !== w) report($sformatf("%s got %h, want %h", name, g, w));
   endtask

   task automatic count_beat(input kind_type k, input logic [BYTE_BITS-1:0] b);
      result_type r;
      if (k == KIND_DATA) begin
         file_bytes = bump(file_bytes);
         if (b == NEWLINE_BYTE) begin
            if (line_len < width_min) width_min = line_len;
            if (line_len > width_max) width_max = line_len;
            file_lines = bump(file_lines);
            if (line_len == '0) file_empty = bump(file_empty);
            line_len = '0;
         end else begin
            line_len = bump(line_len);
         end
      end else begin
         if (line_len != '0) file_lines = bump(file_lines);
         run_bytes = add_sat(run_bytes, file_bytes);
         run_lines = add_sat(run_lines, file_lines);
         run_empty = add_sat(run_empty, file_empty);
         if (file_lines < lines_lo) lines_lo = file_lines;
         if (file_lines > lines_hi) lines_hi = file_lines;
         if (file_bytes < size_lo) size_lo = file_bytes;
         if (file_bytes > size_hi) size_hi = file_bytes;
         r.file_bytes          = low_bits(file_bytes);
         r.file_lines          = low_bits(file_lines);
         r.file_empty_lines    = low_bits(file_empty);
         r.line_width_min      = low_bits(width_min);
         r.line_width_max      = low_bits(width_max);
         r.total_bytes         = low_bits(run_bytes);
         r.total_lines         = low_bits(run_lines);
         r.total_empty_lines   = low_bits(run_empty);
         r.smallest_file_bytes = low_bits(size_lo);
         r.largest_file_bytes  = low_bits(size_hi);
         r.fewest_file_lines   = low_bits(lines_lo);
         r.most_file_lines     = low_bits(lines_hi);
         file_stats_q.push_back(r);
         clear_file();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_file();
         run_bytes = '0;
         run_lines = '0;
         run_empty = '0;
         size_lo   = COUNT_MAX;
         size_hi   = '0;
         lines_lo  = COUNT_MAX;
         lines_hi  = '0;
         file_stats_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (file_stats_q.size() == 0) begin
               report("result beat with no file pending");
            end else begin
               want = file_stats_q.pop_front();
               got  = result_type'(rsp_tdata);
               check_field("file_bytes", got.file_bytes, want.file_bytes);
               check_field("file_lines", got.file_lines, want.file_lines);
               check_field("file_empty_lines", got.file_empty_lines, want.file_empty_lines);
               check_field("line_width_min", got.line_width_min, want.line_width_min);
               check_field("line_width_max", got.line_width_max, want.line_width_max);
               check_field("total_bytes", got.total_bytes, want.total_bytes);
               check_field("total_lines", got.total_lines, want.total_lines);
               check_field("total_empty_lines", got.total_empty_lines,
                           want.total_empty_lines);
               check_field("smallest_file_bytes", got.smallest_file_bytes,
                           want.smallest_file_bytes);
               check_field("largest_file_bytes", got.largest_file_bytes,
                           want.largest_file_bytes);
               check_field("fewest_file_lines", got.fewest_file_lines,
                           want.fewest_file_lines);
               check_field("most_file_lines", got.most_file_lines, want.most_file_lines);
               checked_count <= checked_count + 1;
            end
         end
         if (req_tvalid && req_tready) count_beat(kind_type'(req_tuser), req_tdata);
      end
      pending_count <= file_stats_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the text line statistics block: stimulus, flow control and verdict.
module tb_top;
   import tls_pkg::*;

   localparam int COUNT_BITS     = COUNT_BITS_DEFAULT;
   localparam int RANDOM_BEATS   = 450;
   localparam int TAIL_BEATS     = 70;
   localparam int MIN_FILES      = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [BYTE_BITS-1:0] req_tdata  = '0;   // data_byte
   logic                 req_tuser  = 1'b0; // kind
   logic                 rsp_tready = 1'b0;
   logic                 req_tready;
   logic                 rsp_tvalid;
   logic [RSP_BITS-1:0]  rsp_tdata;

   int          fail_count;
   int          pending_count;
   int          checked_count;
   int          beats_sent  = 0;
   int          files_sent  = 0;
   int          quiet_cycles = 0;
   int unsigned stall_left  = 0;
   bit          gaps_on     = 1'b0;
   bit          stalls_on   = 1'b0;

   text_line_statistics_top #(
      .COUNT_BITS (COUNT_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   text_line_statistics_checker #(
      .COUNT_BITS (COUNT_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (stalls_on && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_beat(input kind_type k, input logic [BYTE_BITS-1:0] b);
      int unsigned idle;
      idle = gaps_on ? pick_gap() : 0;
      if (idle != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= BYTE_BITS'($urandom);
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (k == KIND_EOF) files_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic send_random_file();
      int unsigned len;
      int unsigned nl_pct;
      int unsigned i;
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 20);
      nl_pct = $urandom_range(0, 60);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < nl_pct) send_beat(KIND_DATA, NEWLINE_BYTE);
         else send_beat(KIND_DATA, BYTE_BITS'($urandom));
      end
      if (len != 0 && $urandom_range(0, 1) == 0) send_beat(KIND_DATA, NEWLINE_BYTE);
      send_beat(KIND_EOF, BYTE_BITS'($urandom));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty file, then lines of several widths with a trailing partial line
      send_beat(KIND_EOF, 8'hFF);
      send_beat(KIND_DATA, NEWLINE_BYTE);
      send_beat(KIND_DATA, NEWLINE_BYTE);
      send_beat(KIND_DATA, 8'h41);
      send_beat(KIND_DATA, 8'h00);
      send_beat(KIND_DATA, 8'hFF);
      send_beat(KIND_DATA, NEWLINE_BYTE);
      send_beat(KIND_DATA, 8'h8A);
      send_beat(KIND_DATA, 8'h0B);
      send_beat(KIND_EOF, NEWLINE_BYTE);
      // unterminated line only, single newline, empty file again
      send_beat(KIND_DATA, 8'h55);
      send_beat(KIND_DATA, 8'hAA);
      send_beat(KIND_EOF, 8'h00);
      send_beat(KIND_DATA, NEWLINE_BYTE);
      send_beat(KIND_EOF, 8'h7F);
      send_beat(KIND_EOF, 8'h00);
      wait_drained();

      while (beats_sent < RANDOM_BEATS - TAIL_BEATS || files_sent < MIN_FILES) begin
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) wait_drained();
         send_random_file();
      end

      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      repeat (4) send_random_file();

      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d beats in %0d files sent, %0d results checked", beats_sent, files_sent,
               checked_count);
      $display("covered empty files, unterminated last lines, back-to-back beats and stalls");
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
